// ===== rtl/core/wsfd_pkg.sv =====
package wsfd_pkg;

    localparam int MAX_LEN_W = 21;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 21'h100000;

    // register map, indexed by word address
    localparam logic REG_MAX_LEN = 1'b0;

    // parser phases
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;

    // event codes
    localparam logic [1:0] EV_BYTE  = 2'd0;
    localparam logic [1:0] EV_EMPTY = 2'd1;
    localparam logic [1:0] EV_CLOSE = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // control opcodes
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // short and long extended length markers
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte;
        logic       frame_is_ping;
        logic [3:0] frame_opcode;
        logic       last_byte;
    } wsfd_result_t;

endpackage

// ===== rtl/core/websocket_frame_deframer_core.sv =====
// WebSocket receive deframer: takes one stream byte per request on rx and gives at
// most one event per byte on ev (payload byte, empty frame, close, oversize error).
// A byte is taken in every clock while ev is drained; an event reaches ev through
// the input register, on which the parser works, and then the event register,
// which loads when the parser advances. When the event register is held, the parser
// stalls and rx takes at most one further byte. After close or oversize error the
// block swallows every byte until rst_n. max_frame_length sits at address 0 and
// should be written only while the block is idle. No clearing pass after reset.
module websocket_frame_deframer_core #(
    parameter int LENGTH_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        ev_valid,
    input  logic        ev_ready,
    output logic [1:0]  event_res,
    output logic [7:0]  payload_byte,
    output logic        frame_is_ping,
    output logic [3:0]  frame_opcode,
    output logic        last_byte
);
    import wsfd_pkg::*;

    logic [MAX_LEN_W-1:0] max_len;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_free;
    logic                 adv;
    logic                 res_valid;
    wsfd_result_t         res;

    wsfd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    assign adv      = in_valid_reg && out_free;
    assign rx_ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    wsfd_frame_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .rx_byte   (in_byte_reg),
        .max_len   (max_len),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfd_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (adv && res_valid),
        .res           (res),
        .ev_ready      (ev_ready),
        .free          (out_free),
        .ev_valid      (ev_valid),
        .event_res     (event_res),
        .payload_byte  (payload_byte),
        .frame_is_ping (frame_is_ping),
        .frame_opcode  (frame_opcode),
        .last_byte     (last_byte)
    );

endmodule

// ===== rtl/core/wsfd_apb_regs.sv =====
module wsfd_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [wsfd_pkg::MAX_LEN_W-1:0] max_len
);
    import wsfd_pkg::*;

    logic [MAX_LEN_W-1:0] max_len_reg;
    logic                 wr_max;

    // byte offset bits of the address are ignored
    assign wr_max = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (wr_max)
        begin
            max_len_reg <= pwdata[MAX_LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LEN)
        begin
            prdata = 32'(max_len_reg);
        end
    end

    assign pready  = 1'b1;
    assign max_len = max_len_reg;

endmodule

// ===== rtl/core/wsfd_frame_parser.sv =====
module wsfd_frame_parser #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic [7:0]                     rx_byte,
    input  logic [wsfd_pkg::MAX_LEN_W-1:0] max_len,
    output logic                           res_valid,
    output wsfd_pkg::wsfd_result_t         res
);
    import wsfd_pkg::*;

    logic [2:0]             phase_reg,    phase_next;
    logic [3:0]             opcode_reg,   opcode_next;
    logic                   masked_reg,   masked_next;
    logic [LENGTH_BITS-1:0] len_reg,      len_next;
    logic                   ovf_reg,      ovf_next;
    logic [3:0]             ext_left_reg, ext_left_next;
    logic [31:0]            key_reg,      key_next;
    logic [2:0]             key_left_reg, key_left_next;
    logic [MAX_LEN_W-1:0]   pay_left_reg, pay_left_next;
    logic [1:0]             idx_reg,      idx_next;
    logic                   stopped_reg,  stopped_next;

    logic                   len_done;
    logic [LENGTH_BITS-1:0] len_val;
    logic                   ovf_val;
    logic                   pay_start;
    logic [MAX_LEN_W-1:0]   pay_start_len;
    logic [7:0]             key_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        ext_left_next = ext_left_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        pay_left_next = pay_left_reg;
        idx_next      = idx_reg;
        stopped_next  = stopped_reg;

        len_done      = 1'b0;
        len_val       = '0;
        ovf_val       = 1'b0;
        pay_start     = 1'b0;
        pay_start_len = pay_left_reg;
        key_byte      = '0;

        res_valid         = 1'b0;
        res.event_res     = EV_BYTE;
        res.payload_byte  = '0;
        res.frame_is_ping = (opcode_reg == OP_PING);
        res.frame_opcode  = opcode_reg;
        res.last_byte     = 1'b0;

        if (!stopped_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    key_next    = '0;
                    ovf_next    = 1'b0;
                    if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64)
                    begin
                        ext_left_next = (rx_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                        len_next      = '0;
                        phase_next    = PH_EXT;
                    end
                    else
                    begin
                        len_done = 1'b1;
                        len_val  = LENGTH_BITS'(rx_byte[6:0]);
                    end
                end
                PH_EXT:
                begin
                    // anything shifted out of the top means the length cannot be held
                    ovf_val       = ovf_reg || (len_reg[LENGTH_BITS-1 -: 8] != 8'd0);
                    len_val       = {len_reg[LENGTH_BITS-9:0], rx_byte};
                    ovf_next      = ovf_val;
                    len_next      = len_val;
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_next == 4'd0)
                    begin
                        len_done = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next      = {key_reg[23:0], rx_byte};
                    key_left_next = key_left_reg - 3'd1;
                    if (key_left_next == 3'd0)
                    begin
                        pay_start = 1'b1;
                    end
                end
                PH_PAY:
                begin
                    unique case (idx_reg)
                        2'd0:    key_byte = key_reg[31:24];
                        2'd1:    key_byte = key_reg[23:16];
                        2'd2:    key_byte = key_reg[15:8];
                        default: key_byte = key_reg[7:0];
                    endcase
                    idx_next      = idx_reg + 2'd1;
                    pay_left_next = pay_left_reg - MAX_LEN_W'(1);
                    if (pay_left_next == '0)
                    begin
                        phase_next = PH_HDR0;
                    end
                    if (opcode_reg == OP_CLOSE)
                    begin
                        if (pay_left_next == '0)
                        begin
                            stopped_next  = 1'b1;
                            res_valid     = 1'b1;
                            res.event_res = EV_CLOSE;
                        end
                    end
                    else if (opcode_reg != OP_PONG)
                    begin
                        res_valid        = 1'b1;
                        res.event_res    = EV_BYTE;
                        res.payload_byte = rx_byte ^ key_byte;
                        res.last_byte    = (pay_left_next == '0);
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            // full length known: range check, then key or payload
            if (len_done)
            begin
                if (ovf_val || (len_val > LENGTH_BITS'(max_len)))
                begin
                    stopped_next  = 1'b1;
                    res_valid     = 1'b1;
                    res.event_res = EV_ERROR;
                end
                else
                begin
                    pay_left_next = len_val[MAX_LEN_W-1:0];
                    idx_next      = '0;
                    if (masked_next)
                    begin
                        key_left_next = 3'd4;
                        phase_next    = PH_KEY;
                    end
                    else
                    begin
                        pay_start     = 1'b1;
                        pay_start_len = len_val[MAX_LEN_W-1:0];
                    end
                end
            end

            // header complete: payload follows, or the frame ends here
            if (pay_start)
            begin
                if (pay_start_len != '0)
                begin
                    phase_next = PH_PAY;
                end
                else
                begin
                    phase_next = PH_HDR0;
                    if (opcode_reg == OP_CLOSE)
                    begin
                        stopped_next  = 1'b1;
                        res_valid     = 1'b1;
                        res.event_res = EV_CLOSE;
                    end
                    else if (opcode_reg != OP_PONG)
                    begin
                        res_valid     = 1'b1;
                        res.event_res = EV_EMPTY;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            opcode_reg   <= '0;
            masked_reg   <= 1'b0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            ext_left_reg <= '0;
            key_reg      <= '0;
            key_left_reg <= '0;
            pay_left_reg <= '0;
            idx_reg      <= '0;
            stopped_reg  <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            ext_left_reg <= ext_left_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            pay_left_reg <= pay_left_next;
            idx_reg      <= idx_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

// ===== rtl/core/wsfd_out_reg.sv =====
module wsfd_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  wsfd_pkg::wsfd_result_t res,
    input  logic                   ev_ready,
    output logic                   free,
    output logic                   ev_valid,
    output logic [1:0]             event_res,
    output logic [7:0]             payload_byte,
    output logic                   frame_is_ping,
    output logic [3:0]             frame_opcode,
    output logic                   last_byte
);
    import wsfd_pkg::*;

    logic         valid_reg;
    wsfd_result_t data_reg;

    // a held event blocks the parser until it is taken
    assign free = !valid_reg || ev_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= res;
        end
    end

    assign ev_valid      = valid_reg;
    assign event_res     = data_reg.event_res;
    assign payload_byte  = data_reg.payload_byte;
    assign frame_is_ping = data_reg.frame_is_ping;
    assign frame_opcode  = data_reg.frame_opcode;
    assign last_byte     = data_reg.last_byte;

endmodule

// ===== rtl/core/wsfd_checker.sv =====
module wsfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       ev_valid,
    input logic       ev_ready,
    input logic [1:0] event_res,
    input logic [7:0] payload_byte,
    input logic       frame_is_ping,
    input logic [3:0] frame_opcode,
    input logic       last_byte
);
    import wsfd_pkg::*;

    // once a close or an error is taken, ev_valid drops
    a_stop_final: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_ready && (event_res == EV_CLOSE || event_res == EV_ERROR)
        |=> !ev_valid)
        else $error("event after close or error");

    a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && last_byte |-> event_res == EV_BYTE)
        else $error("last mark on a non-byte event");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_res != EV_BYTE |-> payload_byte == 8'd0)
        else $error("payload data on a non-byte event");

    a_ping_tag: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> frame_is_ping == (frame_opcode == OP_PING))
        else $error("ping tag does not match opcode");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(event_res) && $stable(payload_byte))
        else $error("stalled event changed");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_chk (.*);
